@@ hdl/rrss_pkg.sv @@
// shared types, constants and helpers of the round-robin slot scheduler
package rrss_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

    localparam int FUNC_W     = 2;
    localparam int SLOT_W     = 4;
    localparam int STATUS_W   = 2;
    localparam int LIVE_W     = 5;
    localparam int TICK_W     = 32;
    localparam int IN_BITS    = FUNC_W + SLOT_W;
    localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = STATUS_W + SLOT_W + 1 + SLOT_W + LIVE_W + TICK_W;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CREATE = 2'd0,
        FUNC_KILL   = 2'd1,
        FUNC_TICK   = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_KILL_FREE = 2'd2
    } status_t;

    typedef struct packed {
        logic             start;
        logic             want_free;
        logic [IDX_W-1:0] start_idx;
    } scan_req_t;

    typedef struct packed {
        logic             done;
        logic             hit;
        logic [IDX_W-1:0] idx;
    } scan_status_t;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx == IDX_W'(NUM_SLOTS - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + IDX_W'(1);
        end
        return res;
    endfunction

endpackage

@@ hdl/rrss_scan.sv @@
// slot scanner: probes one slot per cycle in round-robin order for a free or occupied slot
module rrss_scan
    import rrss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  scan_req_t            req,
    input  logic [NUM_SLOTS-1:0] occupied,
    output scan_status_t         status
);

    logic             active_reg, active_next;
    logic             want_free_reg, want_free_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             match;

    assign match = want_free_reg ? ~occupied[idx_reg] : occupied[idx_reg];

    always_comb
    begin
        status.hit  = active_reg & match;
        status.done = active_reg & (match | (left_reg == CNT_W'(1)));
        status.idx  = idx_reg;
    end

    always_comb
    begin
        active_next    = active_reg;
        want_free_next = want_free_reg;
        idx_next       = idx_reg;
        left_next      = left_reg;
        if (req.start)
        begin
            active_next    = 1'b1;
            want_free_next = req.want_free;
            idx_next       = req.start_idx;
            left_next      = CNT_W'(NUM_SLOTS);
        end
        else if (active_reg)
        begin
            if (status.done)
            begin
                active_next = 1'b0;
            end
            else
            begin
                idx_next  = next_idx(idx_reg);
                left_next = left_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            want_free_reg <= 1'b0;
            idx_reg       <= '0;
            left_reg      <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            want_free_reg <= want_free_next;
            idx_reg       <= idx_next;
            left_reg      <= left_next;
        end
    end

endmodule

@@ hdl/round_robin_slot_scheduler.sv @@
// top level of the round-robin slot scheduler: command sequencer, slot table and output register
//
// One command word is taken at a time; s_axis_tready is high only while the sequencer is idle.
// A kill goes from idle straight to the emit state, which loads its result into the output
// register. A create or a tick that has to search passes the scan state first, where the
// scanner probes k slots (1 to NUM_SLOTS), one slot per clock, starting at slot 0 for a
// create and just after the current slot for a tick (slot 0 when there is none). A full-table
// create, or a tick with one task or none, goes straight to the emit state. The result waits
// in the output register, so the next command can be accepted while it is still pending; a
// held-off result stalls the sequencer only when the following result is ready before the
// first has been taken.
module round_robin_slot_scheduler
    import rrss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // func[1:0], slot[5:2], zero pad
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // status[1:0], new_slot[5:2], running_valid[6],
                                             // running_slot[10:7], live_count[15:11],
                                             // tick_count[47:16]
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t               state_reg, state_next;
    func_t                func_reg, func_next;
    status_t              status_reg, status_next;
    logic [IDX_W-1:0]     new_slot_reg, new_slot_next;
    logic [NUM_SLOTS-1:0] occ_reg, occ_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [IDX_W-1:0]     cur_idx_reg, cur_idx_next;
    logic [TICK_W-1:0]    ticks_reg, ticks_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     out_data_reg, out_data_next;

    scan_req_t            scan_req;
    scan_status_t         scan_st;

    func_t                func_in;
    logic [SLOT_W-1:0]    slot_in;
    logic [IDX_W-1:0]     slot_idx;
    logic                 kill_ok;

    assign func_in  = func_t'(s_axis_tdata[FUNC_W-1:0]);
    assign slot_in  = s_axis_tdata[FUNC_W +: SLOT_W];
    assign slot_idx = IDX_W'(slot_in);
    assign kill_ok  = (32'(slot_in) < NUM_SLOTS) && occ_reg[slot_idx];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    rrss_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (scan_req),
        .occupied (occ_reg),
        .status   (scan_st)
    );

    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        status_next    = status_reg;
        new_slot_next  = new_slot_reg;
        occ_next       = occ_reg;
        count_next     = count_reg;
        cur_valid_next = cur_valid_reg;
        cur_idx_next   = cur_idx_reg;
        ticks_next     = ticks_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_data_next  = out_data_reg;
        scan_req       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    func_next     = func_in;
                    status_next   = STATUS_OK;
                    new_slot_next = '0;
                    state_next    = ST_EMIT;
                    case (func_in)
                        FUNC_CREATE:
                        begin
                            if (count_reg < CNT_W'(NUM_SLOTS))
                            begin
                                scan_req.start     = 1'b1;
                                scan_req.want_free = 1'b1;
                                scan_req.start_idx = '0;
                                state_next         = ST_SCAN;
                            end
                            else
                            begin
                                status_next = STATUS_FULL;
                            end
                        end
                        FUNC_KILL:
                        begin
                            if (kill_ok)
                            begin
                                occ_next[slot_idx] = 1'b0;
                                count_next         = count_reg - CNT_W'(1);
                                if (cur_valid_reg && (cur_idx_reg == slot_idx))
                                begin
                                    cur_valid_next = 1'b0;
                                    cur_idx_next   = '0;
                                end
                            end
                            else
                            begin
                                status_next = STATUS_KILL_FREE;
                            end
                        end
                        FUNC_TICK:
                        begin
                            ticks_next = ticks_reg + TICK_W'(1);
                            if (count_reg > CNT_W'(1))
                            begin
                                scan_req.start     = 1'b1;
                                scan_req.want_free = 1'b0;
                                scan_req.start_idx = cur_valid_reg ? next_idx(cur_idx_reg) : '0;
                                state_next         = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (scan_st.done)
                begin
                    if (scan_st.hit)
                    begin
                        if (func_reg == FUNC_CREATE)
                        begin
                            occ_next[scan_st.idx] = 1'b1;
                            count_next            = count_reg + CNT_W'(1);
                            new_slot_next         = scan_st.idx;
                        end
                        else
                        begin
                            cur_valid_next = 1'b1;
                            cur_idx_next   = scan_st.idx;
                        end
                    end
                    else if (func_reg == FUNC_CREATE)
                    begin
                        status_next = STATUS_FULL;
                    end
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = OUT_W'({ticks_reg,
                                             LIVE_W'(count_reg),
                                             cur_valid_reg ? SLOT_W'(cur_idx_reg) : SLOT_W'(0),
                                             cur_valid_reg,
                                             SLOT_W'(new_slot_reg),
                                             status_reg});
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            func_reg      <= FUNC_CREATE;
            status_reg    <= STATUS_OK;
            new_slot_reg  <= '0;
            occ_reg       <= '0;
            count_reg     <= '0;
            cur_valid_reg <= 1'b0;
            cur_idx_reg   <= '0;
            ticks_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            func_reg      <= func_next;
            status_reg    <= status_next;
            new_slot_reg  <= new_slot_next;
            occ_reg       <= occ_next;
            count_reg     <= count_next;
            cur_valid_reg <= cur_valid_next;
            cur_idx_reg   <= cur_idx_next;
            ticks_reg     <= ticks_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule
